[rtl/core/egrid_pkg.sv]
// Shared types and constants of the elevation occupancy grid core.
// No dependencies; compile first.
package egrid_pkg;

  localparam int RES_W      = 16;
  localparam int THR_W      = 24;
  localparam int COUNT_W    = 13;
  localparam int MARGIN_W   = 24;
  localparam int CFG_DATA_W = 24;
  localparam int CFG_IDX_W  = 2;
  localparam int ROW_IDX_W  = 6;
  localparam int ROW_BITS_W = 64;
  localparam int GRID_DIM_W = 7;

  localparam logic [RES_W-1:0]    RESOLUTION_RST = 16'd256;
  localparam logic [THR_W-1:0]    HEIGHT_THR_RST = 24'd51;
  localparam logic [COUNT_W-1:0]  COUNT_THR_RST  = 13'd2;
  localparam logic [MARGIN_W-1:0] MARGIN_RST     = 24'd282;
  localparam logic [COUNT_W-1:0]  COUNT_SAT      = {COUNT_W{1'b1}};

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_RESOLUTION = 2'd0,
    REG_HEIGHT_THR = 2'd1,
    REG_COUNT_THR  = 2'd2,
    REG_MARGIN     = 2'd3
  } cfg_reg_t;

  typedef struct packed {
    logic start;
  } div_ctl_t;

  typedef struct packed {
    logic busy;
    logic done;
  } div_sts_t;

endpackage

[rtl/core/egrid_if.sv]
// Channel interfaces of the elevation occupancy grid core: points in, rows out, config.
// Depends on egrid_pkg.
interface egrid_point_if import egrid_pkg::*; #(parameter int COORD_BITS = 24) ();
  logic                         valid;
  logic                         ready;
  logic signed [COORD_BITS-1:0] point_x;
  logic signed [COORD_BITS-1:0] point_y;
  logic signed [COORD_BITS-1:0] point_z;
  logic                         last_point;
  modport source (output valid, point_x, point_y, point_z, last_point, input ready);
  modport sink   (input valid, point_x, point_y, point_z, last_point, output ready);
endinterface

interface egrid_row_if import egrid_pkg::*; #(parameter int COORD_BITS = 24) ();
  logic                         valid;
  logic                         ready;
  logic [ROW_IDX_W-1:0]         row_index;
  logic [ROW_BITS_W-1:0]        row_bits;
  logic [GRID_DIM_W-1:0]        grid_width;
  logic [GRID_DIM_W-1:0]        grid_height;
  logic signed [COORD_BITS-1:0] origin_x;
  logic signed [COORD_BITS-1:0] origin_y;
  logic                         clipped;
  logic                         last_row;
  modport source (output valid, row_index, row_bits, grid_width, grid_height, origin_x,
                  origin_y, clipped, last_row, input ready);
  modport sink   (input valid, row_index, row_bits, grid_width, grid_height, origin_x,
                  origin_y, clipped, last_row, output ready);
endinterface

interface egrid_cfg_if import egrid_pkg::*; ();
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;
  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

[rtl/core/egrid_divider.sv]
// Restoring divider, one quotient bit per cycle, shared by all grid divisions.
// Depends on egrid_pkg.
module egrid_divider import egrid_pkg::*; #(
  parameter int DW = 24
) (
  input  logic             clk,
  input  logic             rst,
  input  div_ctl_t         ctl,
  input  logic [DW-1:0]    dividend,
  input  logic [RES_W-1:0] divisor,
  output logic [DW-1:0]    quotient,
  output div_sts_t         sts
);

  localparam int CNT_W = $clog2(DW);

  logic [RES_W-1:0] dvs;
  logic [RES_W-1:0] rem;
  logic [DW-1:0]    quo;
  logic [CNT_W-1:0] cnt;
  logic             busy;
  logic             done;
  logic [RES_W:0]   shifted;
  logic             fits;

  assign shifted = {rem, quo[DW-1]};
  assign fits    = shifted >= {1'b0, dvs};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (ctl.start) begin
        rem  <= '0;
        quo  <= dividend;
        dvs  <= divisor;
        cnt  <= CNT_W'(DW - 1);
        busy <= 1'b1;
      end else if (busy) begin
        if (fits) begin
          rem <= RES_W'(shifted - {1'b0, dvs});
        end else begin
          rem <= shifted[RES_W-1:0];
        end
        quo <= {quo[DW-2:0], fits};
        if (cnt == '0) begin
          busy <= 1'b0;
          done <= 1'b1;
        end else begin
          cnt <= cnt - CNT_W'(1);
        end
      end
    end
  end

  assign quotient = quo;
  assign sts.busy = busy;
  assign sts.done = done;

endmodule

[rtl/core/elevation_occupancy_grid_core.sv]
// Top level of the elevation occupancy grid core: sequencer, point store, cell store.
// Depends on egrid_pkg, egrid_if and egrid_divider.
//
// Use: stream points on the points channel, one beat per point, last_point on the
// final beat. During the load phase ready stays high, so every beat is taken as offered.
// Points beyond MAX_POINTS are dropped and flag the build as clipped.
// The beat carrying last_point starts a build, during which points.ready is low:
//   - clearing pass over the GRID_ROWS*GRID_COLS cell store, one cell a cycle,
//   - two divisions sizing the grid (skipped when no point was stored),
//   - per stored point a read and a margin check, plus, when it lies inside, two
//     divisions on the shared divider, a cell read and, if in the grid, a cell update,
//   - per row a read and an evaluation per used column, one closing check, the output beat.
// One row beat goes out per grid row (one beat when the grid has no rows); the
// sequencer holds each row until rows.ready takes it, so a stalled receiver simply
// freezes the build. After the last row the block returns to loading.
// Config writes (cfg channel, always ready) belong to idle periods.
// Reset returns the config registers to their defaults and empties the point store.
module elevation_occupancy_grid_core import egrid_pkg::*; #(
  parameter int MAX_POINTS = 4096,
  parameter int GRID_COLS  = 64,
  parameter int GRID_ROWS  = 64,
  parameter int COORD_BITS = 24
) (
  input  logic             clk,
  input  logic             rst,
  egrid_point_if.sink      points,
  egrid_row_if.source      rows,
  egrid_cfg_if.sink        cfg
);

  localparam int CB    = COORD_BITS;
  localparam int PAW   = $clog2(MAX_POINTS);
  localparam int PCW   = $clog2(MAX_POINTS + 1);
  localparam int CELLS = GRID_ROWS * GRID_COLS;
  localparam int CAW   = $clog2(CELLS);
  localparam int CXW   = $clog2(GRID_COLS);
  localparam int RYW   = $clog2(GRID_ROWS);
  localparam int EW    = ((CB > MARGIN_W) ? CB : MARGIN_W) + 2;
  localparam int CDW   = COUNT_W + 2 * CB;

  typedef enum logic [13:0] {
    S_LOAD   = 14'b00000000000001,
    S_CLEAR  = 14'b00000000000010,
    S_WDIV   = 14'b00000000000100,
    S_HDIV   = 14'b00000000001000,
    S_BOUNDS = 14'b00000000010000,
    S_PRD    = 14'b00000000100000,
    S_PCHK   = 14'b00000001000000,
    S_XDIV   = 14'b00000010000000,
    S_YDIV   = 14'b00000100000000,
    S_CRD    = 14'b00001000000000,
    S_CUPD   = 14'b00010000000000,
    S_RRD    = 14'b00100000000000,
    S_REVAL  = 14'b01000000000000,
    S_OUT    = 14'b10000000000000
  } state_t;

  state_t state;

  // config registers
  logic [RES_W-1:0]    resolution;
  logic [THR_W-1:0]    hgt_thr;
  logic [COUNT_W-1:0]  cnt_thr;
  logic [MARGIN_W-1:0] edge_margin;

  // load side
  logic [PCW-1:0]       loaded;
  logic                 clip;
  logic signed [CB-1:0] xmin, xmax, ymin, ymax;
  logic [3*CB-1:0]      pt_mem [MAX_POINTS];
  logic [3*CB-1:0]      pt_rd;

  // build side
  logic [CAW-1:0]        sweep;
  logic [PCW-1:0]        pidx;
  logic [GRID_DIM_W-1:0] w, h;
  logic signed [EW-1:0]  lo_x, hi_x, lo_y, hi_y;
  logic [CB-1:0]         cx, cy;
  logic [GRID_DIM_W-1:0] r, c;
  logic [ROW_BITS_W-1:0] bits;
  logic                  div_issued;

  // cell store
  logic [CDW-1:0] cell_mem [CELLS];
  logic [CDW-1:0] cell_rd;
  logic           cw_en;
  logic [CAW-1:0] cw_addr;
  logic [CDW-1:0] cw_data;
  logic [CAW-1:0] cr_addr;

  // divider
  div_ctl_t      div_ctl;
  div_sts_t      div_sts;
  logic [CB-1:0] div_num;
  logic [CB-1:0] div_q;
  logic [RES_W-1:0] res_eff;

  logic                  pt_fire;
  logic                  last_pt;
  logic signed [CB-1:0]  px, py, pz;
  logic                  in_box;
  logic                  in_grid;
  logic [CAW-1:0]        upd_addr;
  logic [COUNT_W-1:0]    c_cnt;
  logic signed [CB-1:0]  c_min, c_max;
  logic signed [CB:0]    spread;
  logic                  occupied;
  logic [GRID_DIM_W-1:0] rows_n;
  logic                  is_div_state;

  assign pt_fire = points.valid && points.ready;
  assign points.ready = (state == S_LOAD);
  assign cfg.ready    = 1'b1;

  assign px = pt_rd[3*CB-1:2*CB];
  assign py = pt_rd[2*CB-1:CB];
  assign pz = pt_rd[CB-1:0];

  assign last_pt = ((pidx + PCW'(1)) == loaded);

  // strictly inside the box shrunk by the margin
  assign in_box = (EW'(px) > lo_x) && (EW'(px) < hi_x) &&
                  (EW'(py) > lo_y) && (EW'(py) < hi_y);

  assign in_grid  = (cx < {{(CB-GRID_DIM_W){1'b0}}, w}) &&
                    (cy < {{(CB-GRID_DIM_W){1'b0}}, h});
  assign upd_addr = CAW'(CAW'(cy[RYW-1:0]) * CAW'(GRID_COLS)) + CAW'(cx[CXW-1:0]);

  assign c_cnt  = cell_rd[CDW-1 -: COUNT_W];
  assign c_min  = cell_rd[2*CB-1:CB];
  assign c_max  = cell_rd[CB-1:0];
  assign spread = (CB+1)'(c_max) - (CB+1)'(c_min);
  assign occupied = (EW'(spread) > $signed({{(EW-THR_W){1'b0}}, hgt_thr})) &&
                    (c_cnt > cnt_thr);

  assign rows_n = (h == '0) ? GRID_DIM_W'(1) : h;

  assign res_eff = (resolution == '0) ? RES_W'(1) : resolution;

  // share one divider between grid sizing and per-point binning
  assign is_div_state = ((state == S_WDIV) && (loaded != '0)) || (state == S_HDIV) ||
                        (state == S_XDIV) || (state == S_YDIV);
  assign div_ctl.start = is_div_state && !div_issued;

  always_comb begin
    unique case (state)
      S_WDIV:  div_num = CB'(xmax - xmin);
      S_HDIV:  div_num = CB'(ymax - ymin);
      S_XDIV:  div_num = CB'(px - xmin);
      default: div_num = CB'(py - ymin);
    endcase
  end

  egrid_divider #(.DW(CB)) u_div (
    .clk      (clk),
    .rst      (rst),
    .ctl      (div_ctl),
    .dividend (div_num),
    .divisor  (res_eff),
    .quotient (div_q),
    .sts      (div_sts)
  );

  // cell store ports: clearing pass, read-modify-write of one cell, or row read
  always_comb begin
    cw_en   = 1'b0;
    cw_addr = sweep;
    cw_data = {{COUNT_W{1'b0}}, {1'b0, {(CB-1){1'b1}}}, {1'b1, {(CB-1){1'b0}}}};
    cr_addr = upd_addr;
    if (state == S_CLEAR) begin
      cw_en = 1'b1;
    end else if (state == S_CUPD) begin
      cw_en   = 1'b1;
      cw_addr = upd_addr;
      cw_data = {(c_cnt == COUNT_SAT) ? c_cnt : c_cnt + COUNT_W'(1),
                 (pz < c_min) ? pz : c_min,
                 (pz > c_max) ? pz : c_max};
    end
    if (state == S_RRD) begin
      cr_addr = CAW'(CAW'(r[RYW-1:0]) * CAW'(GRID_COLS)) + CAW'(c[CXW-1:0]);
    end
  end

  always_ff @(posedge clk) begin
    if (cw_en) begin
      cell_mem[cw_addr] <= cw_data;
    end
    cell_rd <= cell_mem[cr_addr];
  end

  always_ff @(posedge clk) begin
    if (pt_fire && (loaded < PCW'(MAX_POINTS))) begin
      pt_mem[loaded[PAW-1:0]] <= {points.point_x, points.point_y, points.point_z};
    end
    pt_rd <= pt_mem[pidx[PAW-1:0]];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_LOAD;
      loaded      <= '0;
      clip        <= 1'b0;
      div_issued  <= 1'b0;
      resolution  <= RESOLUTION_RST;
      hgt_thr     <= HEIGHT_THR_RST;
      cnt_thr     <= COUNT_THR_RST;
      edge_margin <= MARGIN_RST;
    end else begin
      if (cfg.valid && cfg.ready) begin
        unique case (cfg_reg_t'(cfg.index))
          REG_RESOLUTION: resolution  <= cfg.data[RES_W-1:0];
          REG_HEIGHT_THR: hgt_thr     <= cfg.data[THR_W-1:0];
          REG_COUNT_THR:  cnt_thr     <= cfg.data[COUNT_W-1:0];
          REG_MARGIN:     edge_margin <= cfg.data[MARGIN_W-1:0];
        endcase
      end

      unique case (state)
        S_LOAD: begin
          if (pt_fire) begin
            if (loaded >= PCW'(MAX_POINTS)) begin
              clip <= 1'b1;
            end else begin
              if (loaded == '0) begin
                xmin <= points.point_x;
                xmax <= points.point_x;
                ymin <= points.point_y;
                ymax <= points.point_y;
              end else begin
                if (points.point_x < xmin) xmin <= points.point_x;
                if (points.point_x > xmax) xmax <= points.point_x;
                if (points.point_y < ymin) ymin <= points.point_y;
                if (points.point_y > ymax) ymax <= points.point_y;
              end
              loaded <= loaded + PCW'(1);
            end
            if (points.last_point) begin
              sweep <= '0;
              state <= S_CLEAR;
            end
          end
        end
        S_CLEAR: begin
          if (sweep == CAW'(CELLS - 1)) begin
            state <= S_WDIV;
          end else begin
            sweep <= sweep + CAW'(1);
          end
        end
        S_WDIV: begin
          if (loaded == '0) begin
            // empty cloud: zero-sized grid at the origin
            xmin  <= '0;
            ymin  <= '0;
            w     <= '0;
            h     <= '0;
            r     <= '0;
            c     <= '0;
            bits  <= '0;
            state <= S_RRD;
          end else if (!div_issued) begin
            div_issued <= 1'b1;
          end else if (div_sts.done) begin
            div_issued <= 1'b0;
            if (div_q > CB'(GRID_COLS)) begin
              w    <= GRID_DIM_W'(GRID_COLS);
              clip <= 1'b1;
            end else begin
              w <= div_q[GRID_DIM_W-1:0];
            end
            state <= S_HDIV;
          end
        end
        S_HDIV: begin
          if (!div_issued) begin
            div_issued <= 1'b1;
          end else if (div_sts.done) begin
            div_issued <= 1'b0;
            if (div_q > CB'(GRID_ROWS)) begin
              h    <= GRID_DIM_W'(GRID_ROWS);
              clip <= 1'b1;
            end else begin
              h <= div_q[GRID_DIM_W-1:0];
            end
            state <= S_BOUNDS;
          end
        end
        S_BOUNDS: begin
          lo_x  <= EW'(xmin) + EW'(edge_margin);
          hi_x  <= EW'(xmax) - EW'(edge_margin);
          lo_y  <= EW'(ymin) + EW'(edge_margin);
          hi_y  <= EW'(ymax) - EW'(edge_margin);
          pidx  <= '0;
          state <= S_PRD;
        end
        S_PRD: begin
          state <= S_PCHK;
        end
        S_PCHK: begin
          if (in_box) begin
            state <= S_XDIV;
          end else if (last_pt) begin
            r     <= '0;
            c     <= '0;
            bits  <= '0;
            state <= S_RRD;
          end else begin
            pidx  <= pidx + PCW'(1);
            state <= S_PRD;
          end
        end
        S_XDIV: begin
          if (!div_issued) begin
            div_issued <= 1'b1;
          end else if (div_sts.done) begin
            div_issued <= 1'b0;
            cx         <= div_q;
            state      <= S_YDIV;
          end
        end
        S_YDIV: begin
          if (!div_issued) begin
            div_issued <= 1'b1;
          end else if (div_sts.done) begin
            div_issued <= 1'b0;
            cy         <= div_q;
            state      <= S_CRD;
          end
        end
        S_CRD: begin
          if (in_grid) begin
            state <= S_CUPD;
          end else if (last_pt) begin
            r     <= '0;
            c     <= '0;
            bits  <= '0;
            state <= S_RRD;
          end else begin
            pidx  <= pidx + PCW'(1);
            state <= S_PRD;
          end
        end
        S_CUPD: begin
          if (last_pt) begin
            r     <= '0;
            c     <= '0;
            bits  <= '0;
            state <= S_RRD;
          end else begin
            pidx  <= pidx + PCW'(1);
            state <= S_PRD;
          end
        end
        S_RRD: begin
          if ((h != '0) && (c < w)) begin
            state <= S_REVAL;
          end else begin
            state <= S_OUT;
          end
        end
        S_REVAL: begin
          if (occupied) begin
            bits[c[ROW_IDX_W-1:0]] <= 1'b1;
          end
          c     <= c + GRID_DIM_W'(1);
          state <= S_RRD;
        end
        S_OUT: begin
          if (rows.ready) begin
            if (rows.last_row) begin
              loaded <= '0;
              clip   <= 1'b0;
              state  <= S_LOAD;
            end else begin
              r     <= r + GRID_DIM_W'(1);
              c     <= '0;
              bits  <= '0;
              state <= S_RRD;
            end
          end
        end
        default: state <= S_LOAD;
      endcase
    end
  end

  assign rows.valid       = (state == S_OUT);
  assign rows.row_index   = r[ROW_IDX_W-1:0];
  assign rows.row_bits    = bits;
  assign rows.grid_width  = w;
  assign rows.grid_height = h;
  assign rows.origin_x    = xmin;
  assign rows.origin_y    = ymin;
  assign rows.clipped     = clip;
  assign rows.last_row    = ((r + GRID_DIM_W'(1)) == rows_n);

  a_busy_while_out: assert property (@(posedge clk) disable iff (rst)
    rows.valid |-> !points.ready) else $error("point taken while a row is pending");

  a_store_bound: assert property (@(posedge clk) disable iff (rst)
    loaded <= PCW'(MAX_POINTS)) else $error("point count past store depth");

  a_div_idle_start: assert property (@(posedge clk) disable iff (rst)
    div_ctl.start |-> !div_sts.busy) else $error("divider restarted while busy");

  a_empty_grid_row: assert property (@(posedge clk) disable iff (rst)
    (rows.valid && (h == '0)) |-> (rows.last_row && (r == '0) && (bits == '0)))
    else $error("empty grid row malformed");

  a_rows_in_range: assert property (@(posedge clk) disable iff (rst)
    rows.valid |-> (r < rows_n)) else $error("row index beyond grid height");

endmodule
